// ===== hw/rtl/led_frame_buffer_packer_top_macros.svh =====
// Assertion macros shared by the frame buffer packer checker.
// No dependencies; included by the checker file only.
`ifndef LED_FRAME_BUFFER_PACKER_TOP_MACROS_SVH
`define LED_FRAME_BUFFER_PACKER_TOP_MACROS_SVH

// Same-cycle implication under active-low reset
`define LFBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfbp check failed");

// Next-cycle implication under active-low reset
`define LFBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfbp check failed");

`endif

// ===== hw/rtl/lfbp_pkg.sv =====
// Shared codes, masks and controller/datapath interface types for the
// LED frame buffer packer. No dependencies.
package lfbp_pkg;

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TX    = 2'd2;

  // Raster operation codes
  localparam logic [1:0] OVL_REPLACE = 2'd0;
  localparam logic [1:0] OVL_OR      = 2'd1;
  localparam logic [1:0] OVL_ANDNOT  = 2'd2;
  localparam logic [1:0] OVL_XOR     = 2'd3;

  // Transmit mode codes
  localparam logic [7:0] MODE_4BIT = 8'd0;
  localparam logic [7:0] MODE_2BIT = 8'd1;
  localparam logic [7:0] MODE_1BIT = 8'd2;

  // Pair masks for 2-bit packing
  localparam logic [7:0] MASK_PAIR_A = 8'hC0;
  localparam logic [7:0] MASK_PAIR_B = 8'h30;
  localparam logic [7:0] MASK_PAIR_C = 8'h0C;
  localparam logic [7:0] MASK_PAIR_D = 8'h03;

  // Result source select
  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_MODE = 2'd1,
    RES_MEM  = 2'd2,
    RES_PACK = 2'd3
  } res_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_en;
    logic latch_en;
    logic rd0_en;
    logic rd1_en;
    logic wr_en;
    logic out_load;
  } lfbp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_rd;
    logic need_second;
    logic is_write;
    logic clear_last;
  } lfbp_stat_t;

endpackage

// ===== hw/rtl/led_frame_buffer_packer_top.sv =====
// LED frame buffer packer top: column-major pixel store with raster writes and reads.
// Steps per item: latch on accept, a memory read when the item needs one, then
// a second read (packed 2-bit byte) or a write (pixel write), then the output word.
// One item at a time; a held output word stalls the input.
// Depends on lfbp_pkg, lfbp_ctrl and lfbp_dp.
// Reset: clearing pass over all WIDTH*HEIGHT pixels with in_ready_o low; pack mode 0.
module led_frame_buffer_packer_top #(
  parameter int WIDTH  = 16,
  parameter int HEIGHT = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_pack_mode_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [7:0]         pixel_value_i,
  input  logic [1:0]         overlay_i,
  input  logic [15:0]        tx_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         data_o,
  output logic               in_range_o
);
  import lfbp_pkg::*;

  lfbp_cmd_t  cmd;
  lfbp_stat_t stat;

  // Mode register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  lfbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  lfbp_dp #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_pack_mode_i (cfg_pack_mode_i),
    .op_i            (op_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pixel_value_i   (pixel_value_i),
    .overlay_i       (overlay_i),
    .tx_index_i      (tx_index_i),
    .data_o          (data_o),
    .in_range_o      (in_range_o)
  );

endmodule

// ===== hw/rtl/lfbp_ctrl.sv =====
// Sequencing controller for the frame buffer packer: clearing pass,
// item acceptance, memory read/write steps and output word handoff.
// Depends on lfbp_pkg.
module lfbp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lfbp_pkg::lfbp_cmd_t cmd_o,
  input  lfbp_pkg::lfbp_stat_t stat_i
);
  import lfbp_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD0   = 6'b000100,
    S_RD1   = 6'b001000,
    S_WR    = 6'b010000,
    S_RES   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (stat_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.latch_en = 1'b1;
          state_d        = S_RD0;
        end
      end
      S_RD0: begin
        if (stat_i.need_rd) begin
          cmd_o.rd0_en = 1'b1;
          if (stat_i.need_second) begin
            state_d = S_RD1;
          end else if (stat_i.is_write) begin
            state_d = S_WR;
          end else begin
            state_d = S_RES;
          end
        end else begin
          state_d = S_RES;
        end
      end
      S_RD1: begin
        cmd_o.rd1_en = 1'b1;
        state_d      = S_RES;
      end
      S_WR: begin
        cmd_o.wr_en = 1'b1;
        state_d     = S_RES;
      end
      S_RES: begin
        // hold the result until the output register is free
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/lfbp_dp.sv =====
// Datapath for the frame buffer packer: item decode, pixel memory,
// raster operations, transmit packing, mode register and output word.
// Depends on lfbp_pkg.
module lfbp_dp #(
  parameter int WIDTH  = 16,
  parameter int HEIGHT = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lfbp_pkg::lfbp_cmd_t  cmd_i,
  output lfbp_pkg::lfbp_stat_t stat_o,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_pack_mode_i,
  input  logic [1:0]           op_i,
  input  logic signed [15:0]   pos_x_i,
  input  logic signed [15:0]   pos_y_i,
  input  logic [7:0]           pixel_value_i,
  input  logic [1:0]           overlay_i,
  input  logic [15:0]          tx_index_i,
  output logic [7:0]           data_o,
  output logic                 in_range_o
);
  import lfbp_pkg::*;

  localparam int N       = WIDTH * HEIGHT;
  localparam int AW      = (N > 1) ? $clog2(N) : 1;
  localparam int QUARTER = N / 4;

  // Pixel memory and read register
  logic [7:0]    mem [N];
  logic [7:0]    rdata_q;
  logic [7:0]    byte0_q;

  // Mode register and clear counter
  logic [7:0]    pack_mode_q;
  logic [AW-1:0] clr_addr_q;

  // Latched item
  res_sel_e      sel_q, sel_d;
  logic          ok_q, ok_d;
  logic          need_rd_q, need_rd_d;
  logic          need_second_q, need_second_d;
  logic          is_write_q, is_write_d;
  logic [AW-1:0] addr0_q, addr0_d;
  logic [AW-1:0] addr1_q, addr1_d;
  logic [7:0]    val_q;
  logic [1:0]    ovl_q;
  logic [7:0]    mode_q;

  // Output word
  logic [7:0]    data_q;
  logic          in_range_q;

  // Decode helpers
  logic          pix_ok;
  logic [16:0]   pix_lin;
  logic [15:0]   tx_k;
  logic [16:0]   tx_even;
  logic [16:0]   tx_odd;

  // Memory port signals
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    rop_value;
  logic [7:0]    pack_a;
  logic [7:0]    pack_value;
  logic [7:0]    result;

  // Locate pixel, column-major address
  assign pix_ok = !pos_x_i[15] && !pos_y_i[15]
               && ($unsigned(pos_x_i) < 16'(WIDTH))
               && ($unsigned(pos_y_i) < 16'(HEIGHT));
  assign pix_lin = 17'(pos_x_i[7:0]) * 17'(HEIGHT) + 17'(pos_y_i[7:0]);

  // Transmit byte positions
  assign tx_k    = tx_index_i - 16'd1;
  assign tx_even = {tx_k, 1'b0};
  assign tx_odd  = {tx_k, 1'b1};

  // Decode the incoming word
  always_comb begin
    sel_d         = RES_ZERO;
    ok_d          = 1'b0;
    need_rd_d     = 1'b0;
    need_second_d = 1'b0;
    is_write_d    = 1'b0;
    addr0_d       = pix_lin[AW-1:0];
    addr1_d       = pix_lin[AW-1:0];
    case (op_i)
      OP_WRITE: begin
        ok_d       = pix_ok;
        need_rd_d  = pix_ok;
        is_write_d = pix_ok;
      end
      OP_READ: begin
        ok_d      = pix_ok;
        need_rd_d = pix_ok;
        sel_d     = pix_ok ? RES_MEM : RES_ZERO;
      end
      OP_TX: begin
        if (tx_index_i == 16'd0) begin
          ok_d  = 1'b1;
          sel_d = RES_MODE;
        end else begin
          case (pack_mode_q)
            MODE_4BIT: begin
              ok_d      = (17'(tx_k) < 17'(N));
              need_rd_d = ok_d;
              addr0_d   = tx_k[AW-1:0];
              sel_d     = ok_d ? RES_MEM : RES_ZERO;
            end
            MODE_2BIT: begin
              ok_d          = (18'(tx_odd) < 18'(N));
              need_rd_d     = ok_d;
              need_second_d = ok_d;
              addr0_d       = tx_even[AW-1:0];
              addr1_d       = tx_odd[AW-1:0];
              sel_d         = ok_d ? RES_PACK : RES_ZERO;
            end
            MODE_1BIT: begin
              ok_d = (17'(tx_k) < 17'(QUARTER));
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // Latch the item on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_en) begin
      sel_q         <= sel_d;
      ok_q          <= ok_d;
      need_rd_q     <= need_rd_d;
      need_second_q <= need_second_d;
      is_write_q    <= is_write_d;
      addr0_q       <= addr0_d;
      addr1_q       <= addr1_d;
      val_q         <= pixel_value_i;
      ovl_q         <= overlay_i;
      mode_q        <= pack_mode_q;
    end
  end

  assign stat_o.need_rd     = need_rd_q;
  assign stat_o.need_second = need_second_q;
  assign stat_o.is_write    = is_write_q;
  assign stat_o.clear_last  = (clr_addr_q == AW'(N - 1));

  // Mode register and clear sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_mode_q <= MODE_4BIT;
      clr_addr_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        pack_mode_q <= cfg_pack_mode_i;
      end
      if (cmd_i.clear_en && !stat_o.clear_last) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  // Raster operation on the current pixel
  always_comb begin
    case (ovl_q)
      OVL_REPLACE: rop_value = val_q;
      OVL_OR:      rop_value = rdata_q | val_q;
      OVL_ANDNOT:  rop_value = rdata_q & ~val_q;
      OVL_XOR:     rop_value = rdata_q ^ val_q;
      default:     rop_value = val_q;
    endcase
  end

  // Memory port muxing
  assign mem_we    = cmd_i.clear_en || cmd_i.wr_en;
  assign mem_waddr = cmd_i.clear_en ? clr_addr_q : addr0_q;
  assign mem_wdata = cmd_i.clear_en ? 8'd0 : rop_value;
  assign mem_re    = cmd_i.rd0_en || cmd_i.rd1_en;
  assign mem_raddr = cmd_i.rd1_en ? addr1_q : addr0_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Keep the first pixel of a packed pair
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd1_en) begin
      byte0_q <= rdata_q;
    end
  end

  // Pack two pixels into one byte
  assign pack_a     = {byte0_q[3:0], 4'b0000};
  assign pack_value = (pack_a & MASK_PAIR_A) | (pack_a & MASK_PAIR_B)
                    | (rdata_q & MASK_PAIR_C) | (rdata_q & MASK_PAIR_D);

  // Select the result byte
  always_comb begin
    case (sel_q)
      RES_MODE: result = mode_q;
      RES_MEM:  result = rdata_q;
      RES_PACK: result = pack_value;
      default:  result = 8'd0;
    endcase
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      data_q     <= result;
      in_range_q <= ok_q;
    end
  end

  assign data_o     = data_q;
  assign in_range_o = in_range_q;

endmodule

// ===== hw/rtl/lfbp_checker.sv =====
// Port-level checks for the LED frame buffer packer top level.
// Depends on the assertion macro header; bound to the top level below.
`include "led_frame_buffer_packer_top_macros.svh"

module lfbp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] data_o,
  input logic       in_range_o
);

  // A stalled output word holds
  `LFBP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(data_o) && $stable(in_range_o))

  // Out-of-range results carry zero data
  `LFBP_ASSERT_NOW(a_oor_zero, clk_i, rst_ni, out_valid_o && !in_range_o, data_o == 8'd0)

  // One item in flight: no accept right after an accept
  `LFBP_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // Mode register never stalls a write
  `LFBP_ASSERT_NOW(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o)

endmodule

bind led_frame_buffer_packer_top lfbp_checker u_lfbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .data_o      (data_o),
  .in_range_o  (in_range_o)
);
